### hdl/id3fp_pkg.sv
// Shared types and constants for the ID3v2 frame parser.
`timescale 1ns / 1ps
package id3fp_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [2:0] {
    K_TAG_HDR   = 3'd0,
    K_FRAME_HDR = 3'd1,
    K_BODY      = 3'd2,
    K_TAG_END   = 3'd3,
    K_NO_TAG    = 3'd4,
    K_TRUNC     = 3'd5
  } kind_t;

  typedef enum logic [5:0] {
    PH_MARKER     = 6'b000001,
    PH_HEADER     = 6'b000010,
    PH_FRAME_HDR  = 6'b000100,
    PH_FIRST_BODY = 6'b001000,
    PH_BODY       = 6'b010000,
    PH_DONE       = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  version_major;
    logic [7:0]  version_revision;
    logic [7:0]  tag_flags;
    logic [27:0] tag_len;
    logic [31:0] frm_id;
    logic [31:0] frm_size;
    logic [15:0] frame_flags;
    logic        zero_byte_present;
    logic [7:0]  body_byte;
    logic        last;
  } result_t;

  // "ID3"
  function automatic logic [7:0] marker_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h49;
      2'd1:    c = 8'h44;
      2'd2:    c = 8'h33;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/id3v2_frame_parser_core.sv
// ID3v2 tag and frame parser core, one file byte per input transaction.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall): one file byte per transaction in
//   in_data_byte; in_stream_end = 1 marks end of file (data ignored).
//   Output channel (out_valid / out_stall): one parsed record per
//   transaction, kind in out_kind; fields not belonging to the kind are 0.
//   Each input byte updates the parser state in the cycle it is taken and
//   writes zero, one or two records into a 4-entry output queue. The first
//   record of a byte is registered in the queue before it is offered.
//   Throughput: one byte per cycle while in_stall is low. Only the first
//   body byte of a frame yields two records; in_stall rises while fewer than
//   two queue entries are free, so the queue's single read port sets the
//   sustained rate of one record per cycle.
//   When the receiver stalls, the queue head holds and input stalls once
//   fewer than two queue entries are free. After tag end, no tag or
//   truncation, input bytes are taken and dropped.
//   Reset (synchronous, rst_n low) empties the queue and returns the parser
//   to the marker check; no clearing pass is needed.
module id3v2_frame_parser_core
  import id3fp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_version_major,
  output logic [7:0]  out_version_revision,
  output logic [7:0]  out_tag_flags,
  output logic [27:0] out_tag_len,
  output logic [31:0] out_frm_id,
  output logic [31:0] out_frm_size,
  output logic [15:0] out_frame_flags,
  output logic        out_zero_byte_present,
  output logic [7:0]  out_body_byte,
  output logic        out_last
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  field_count_r, field_count_nxt;
  logic [31:0] shift_word_r, shift_word_nxt;
  logic [27:0] tag_len_r, tag_len_nxt;
  logic [32:0] consumed_r, consumed_nxt;
  logic [31:0] frm_id_r, frm_id_nxt;
  logic [31:0] frm_size_r, frm_size_nxt;
  logic [15:0] frame_flags_r, frame_flags_nxt;
  logic [31:0] body_left_r, body_left_nxt;
  logic [23:0] header_bytes_r, header_bytes_nxt;

  result_t             queue_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  result_t     res0, res1;
  logic [1:0]  push_n;
  logic        in_xact, out_xact;
  result_t     head;

  assign in_stall  = count_r > QCNT_W'(QDEPTH - 2);
  assign in_xact   = in_valid && !in_stall;
  assign out_valid = count_r != '0;
  assign out_xact  = out_valid && !out_stall;

  always_comb begin
    phase_nxt        = phase_r;
    field_count_nxt  = field_count_r;
    shift_word_nxt   = shift_word_r;
    tag_len_nxt      = tag_len_r;
    consumed_nxt     = consumed_r;
    frm_id_nxt       = frm_id_r;
    frm_size_nxt     = frm_size_r;
    frame_flags_nxt  = frame_flags_r;
    body_left_nxt    = body_left_r;
    header_bytes_nxt = header_bytes_r;
    res0             = '0;
    res1             = '0;
    push_n           = 2'd0;
    if (in_xact) begin
      case (phase_r)
        PH_MARKER: begin
          if (in_stream_end || in_data_byte != marker_char(field_count_r[1:0])) begin
            res0.kind = K_NO_TAG;
            push_n    = 2'd1;
            phase_nxt = PH_DONE;
          end else if (field_count_r == 4'd2) begin
            phase_nxt       = PH_HEADER;
            field_count_nxt = '0;
          end else begin
            field_count_nxt = field_count_r + 4'd1;
          end
        end
        PH_HEADER: begin
          if (in_stream_end) begin
            res0.kind = K_TRUNC;
            push_n    = 2'd1;
            phase_nxt = PH_DONE;
          end else begin
            if (field_count_r < 4'd3) begin
              header_bytes_nxt = {header_bytes_r[15:0], in_data_byte};
            end else begin
              shift_word_nxt = {4'b0, shift_word_r[20:0], in_data_byte[6:0]};
            end
            field_count_nxt = field_count_r + 4'd1;
            if (field_count_r == 4'd6) begin
              tag_len_nxt            = shift_word_nxt[27:0];
              res0.kind              = K_TAG_HDR;
              res0.version_major     = header_bytes_nxt[23:16];
              res0.version_revision  = header_bytes_nxt[15:8];
              res0.tag_flags         = header_bytes_nxt[7:0];
              res0.tag_len           = shift_word_nxt[27:0];
              push_n                 = 2'd1;
              consumed_nxt           = '0;
              phase_nxt              = PH_FRAME_HDR;
              field_count_nxt        = '0;
            end
          end
        end
        PH_FRAME_HDR: begin
          if (field_count_r == 4'd0 && consumed_r >= {5'b0, tag_len_r}) begin
            res0.kind = K_TAG_END;
            push_n    = 2'd1;
            phase_nxt = PH_DONE;
          end else if (in_stream_end) begin
            res0.kind = K_TRUNC;
            push_n    = 2'd1;
            phase_nxt = PH_DONE;
          end else begin
            shift_word_nxt  = {shift_word_r[23:0], in_data_byte};
            field_count_nxt = field_count_r + 4'd1;
            if (field_count_r == 4'd3) begin
              frm_id_nxt = shift_word_nxt;
            end else if (field_count_r == 4'd7) begin
              frm_size_nxt = shift_word_nxt;
            end else if (field_count_r >= 4'd9) begin
              frame_flags_nxt = shift_word_nxt[15:0];
              field_count_nxt = '0;
              if (frm_size_r == '0) begin
                res0.kind = K_TAG_END;
                push_n    = 2'd1;
                phase_nxt = PH_DONE;
              end else begin
                consumed_nxt = consumed_r + {1'b0, frm_size_r} + 33'd10;
                phase_nxt    = PH_FIRST_BODY;
              end
            end
          end
        end
        PH_FIRST_BODY: begin
          if (in_stream_end) begin
            res0.kind = K_TRUNC;
            push_n    = 2'd1;
            phase_nxt = PH_DONE;
          end else begin
            res0.kind              = K_FRAME_HDR;
            res0.frm_id            = frm_id_r;
            res0.frm_size          = frm_size_r;
            res0.frame_flags       = frame_flags_r;
            res0.zero_byte_present = in_data_byte == 8'h00;
            body_left_nxt          = frm_size_r - 32'd1;
            push_n                 = 2'd1;
            if (in_data_byte != 8'h00) begin
              res1.kind      = K_BODY;
              res1.body_byte = in_data_byte;
              res1.last      = body_left_nxt == '0;
              push_n         = 2'd2;
            end
            field_count_nxt = '0;
            phase_nxt       = (body_left_nxt == '0) ? PH_FRAME_HDR : PH_BODY;
          end
        end
        PH_BODY: begin
          if (in_stream_end) begin
            res0.kind = K_TRUNC;
            push_n    = 2'd1;
            phase_nxt = PH_DONE;
          end else begin
            res0.kind      = K_BODY;
            res0.body_byte = in_data_byte;
            res0.last      = body_left_r <= 32'd1;
            push_n         = 2'd1;
            if (body_left_r != '0) begin
              body_left_nxt = body_left_r - 32'd1;
            end
            if (body_left_nxt == '0) begin
              phase_nxt       = PH_FRAME_HDR;
              field_count_nxt = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_MARKER;
      field_count_r  <= '0;
      shift_word_r   <= '0;
      tag_len_r      <= '0;
      consumed_r     <= '0;
      frm_id_r       <= '0;
      frm_size_r     <= '0;
      frame_flags_r  <= '0;
      body_left_r    <= '0;
      header_bytes_r <= '0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      count_r        <= '0;
    end else begin
      phase_r        <= phase_nxt;
      field_count_r  <= field_count_nxt;
      shift_word_r   <= shift_word_nxt;
      tag_len_r      <= tag_len_nxt;
      consumed_r     <= consumed_nxt;
      frm_id_r       <= frm_id_nxt;
      frm_size_r     <= frm_size_nxt;
      frame_flags_r  <= frame_flags_nxt;
      body_left_r    <= body_left_nxt;
      header_bytes_r <= header_bytes_nxt;
      wr_ptr_r       <= wr_ptr_r + QPTR_W'(push_n);
      if (out_xact) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push_n) - QCNT_W'(out_xact);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  assign head                  = queue_r[rd_ptr_r];
  assign out_kind              = head.kind;
  assign out_version_major     = head.version_major;
  assign out_version_revision  = head.version_revision;
  assign out_tag_flags         = head.tag_flags;
  assign out_tag_len           = head.tag_len;
  assign out_frm_id            = head.frm_id;
  assign out_frm_size          = head.frm_size;
  assign out_frame_flags       = head.frame_flags;
  assign out_zero_byte_present = head.zero_byte_present;
  assign out_body_byte         = head.body_byte;
  assign out_last              = head.last;

endmodule

### hdl/id3fp_checker.sv
// Port-level checker for the ID3v2 frame parser core, with its bind.
`timescale 1ns / 1ps
module id3fp_checker
  import id3fp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_body_byte,
  input logic        out_last
);

  logic terminal;
  assign terminal = out_kind == K_TAG_END || out_kind == K_NO_TAG || out_kind == K_TRUNC;

  // a terminal record is the last one ever produced
  a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && terminal |=> !out_valid)
    else $error("record delivered after terminal record");

  // input only backs up when results are pending
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_body_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_BODY |-> out_body_byte == 8'h00 && !out_last)
    else $error("body fields set on non-body record");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_body_byte))
    else $error("stalled output transaction changed");

endmodule

bind id3v2_frame_parser_core id3fp_checker u_id3fp_checker (.*);

### bench/tb.sv
// Self-checking testbench for id3v2_frame_parser_core: one random tag stream with a scoreboard.
`timescale 1ns / 1ps
module tb;
  import id3fp_pkg::*;

  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STREAM_TARGET = 1130;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam logic [23:0] TAG_MARKER = 24'h494433;

  typedef enum int {
    END_TAG_SIZE,
    END_ZERO_FRAME,
    END_IN_BODY,
    END_IN_HEADER
  } end_mode_t;

  class frame_scoreboard;
    result_t     expected_q[$];
    int unsigned checked;
    int unsigned mismatches;
    phase_t      ph;
    int unsigned fcount;
    logic [31:0] shift;
    logic [27:0] tsize;
    logic [32:0] consumed;
    logic [31:0] fid;
    logic [31:0] fsize;
    logic [31:0] left;
    logic [15:0] fflags;
    logic [23:0] hdr;

    function new();
      checked = 0;
      mismatches = 0;
      ph = PH_MARKER;
      fcount = 0;
      shift = '0;
      tsize = '0;
      consumed = '0;
      fid = '0;
      fsize = '0;
      left = '0;
      fflags = '0;
      hdr = '0;
    endfunction

    function result_t blank_record(kind_t k);
      result_t r;
      r = '0;
      r.kind = k;
      return r;
    endfunction

    function void close_parse(kind_t k);
      expected_q.push_back(blank_record(k));
      ph = PH_DONE;
    endfunction

    function void note_input(logic [7:0] b, logic eos);
      result_t r;
      case (ph)
        PH_MARKER: begin
          if (eos || b != TAG_MARKER[23 - 8 * fcount -: 8]) begin
            close_parse(K_NO_TAG);
          end else begin
            fcount++;
            if (fcount == 3) begin
              ph = PH_HEADER;
              fcount = 0;
            end
          end
        end
        PH_HEADER: begin
          if (eos) begin
            close_parse(K_TRUNC);
          end else begin
            if (fcount < 3) hdr = {hdr[15:0], b};
            else shift = {4'h0, shift[20:0], b[6:0]};
            fcount++;
            if (fcount >= 7) begin
              tsize = shift[27:0];
              r = blank_record(K_TAG_HDR);
              r.version_major = hdr[23:16];
              r.version_revision = hdr[15:8];
              r.tag_flags = hdr[7:0];
              r.tag_len = tsize;
              expected_q.push_back(r);
              consumed = '0;
              ph = PH_FRAME_HDR;
              fcount = 0;
            end
          end
        end
        PH_FRAME_HDR: begin
          if (fcount == 0 && consumed >= {5'd0, tsize}) begin
            close_parse(K_TAG_END);
          end else if (eos) begin
            close_parse(K_TRUNC);
          end else begin
            shift = {shift[23:0], b};
            fcount++;
            if (fcount == 4) begin
              fid = shift;
            end else if (fcount == 8) begin
              fsize = shift;
            end else if (fcount >= 10) begin
              fflags = shift[15:0];
              fcount = 0;
              if (fsize == 0) begin
                close_parse(K_TAG_END);
              end else begin
                consumed = consumed + {1'b0, fsize} + 33'd10;
                ph = PH_FIRST_BODY;
              end
            end
          end
        end
        PH_FIRST_BODY: begin
          if (eos) begin
            close_parse(K_TRUNC);
          end else begin
            r = blank_record(K_FRAME_HDR);
            r.frm_id = fid;
            r.frm_size = fsize;
            r.frame_flags = fflags;
            r.zero_byte_present = (b == 8'h00);
            expected_q.push_back(r);
            left = fsize - 32'd1;
            if (b != 8'h00) begin
              r = blank_record(K_BODY);
              r.body_byte = b;
              r.last = (left == 0);
              expected_q.push_back(r);
            end
            fcount = 0;
            ph = (left == 0) ? PH_FRAME_HDR : PH_BODY;
          end
        end
        PH_BODY: begin
          if (eos) begin
            close_parse(K_TRUNC);
          end else begin
            r = blank_record(K_BODY);
            r.body_byte = b;
            r.last = (left <= 1);
            expected_q.push_back(r);
            if (left > 0) left--;
            if (left == 0) begin
              ph = PH_FRAME_HDR;
              fcount = 0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   diffs;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected output transaction, kind %0d", got.kind);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      diffs = "";
      if (got.kind !== want.kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", want.kind, got.kind)};
      if (got.version_major !== want.version_major)
        diffs = {diffs, $sformatf(" vmaj %h/%h", want.version_major, got.version_major)};
      if (got.version_revision !== want.version_revision)
        diffs = {diffs, $sformatf(" vrev %h/%h", want.version_revision, got.version_revision)};
      if (got.tag_flags !== want.tag_flags)
        diffs = {diffs, $sformatf(" tflags %h/%h", want.tag_flags, got.tag_flags)};
      if (got.tag_len !== want.tag_len)
        diffs = {diffs, $sformatf(" tsize %h/%h", want.tag_len, got.tag_len)};
      if (got.frm_id !== want.frm_id)
        diffs = {diffs, $sformatf(" fid %h/%h", want.frm_id, got.frm_id)};
      if (got.frm_size !== want.frm_size)
        diffs = {diffs, $sformatf(" fsize %h/%h", want.frm_size, got.frm_size)};
      if (got.frame_flags !== want.frame_flags)
        diffs = {diffs, $sformatf(" fflags %h/%h", want.frame_flags, got.frame_flags)};
      if (got.zero_byte_present !== want.zero_byte_present)
        diffs = {diffs, $sformatf(" zero %b/%b", want.zero_byte_present, got.zero_byte_present)};
      if (got.body_byte !== want.body_byte)
        diffs = {diffs, $sformatf(" body %h/%h", want.body_byte, got.body_byte)};
      if (got.last !== want.last)
        diffs = {diffs, $sformatf(" last %b/%b", want.last, got.last)};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: record %0d mismatch (expected/actual):%s", checked, diffs);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_stream_end;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_version_major;
  logic [7:0]  out_version_revision;
  logic [7:0]  out_tag_flags;
  logic [27:0] out_tag_len;
  logic [31:0] out_frm_id;
  logic [31:0] out_frm_size;
  logic [15:0] out_frame_flags;
  logic        out_zero_byte_present;
  logic [7:0]  out_body_byte;
  logic        out_last;

  frame_scoreboard sb;
  logic [7:0]      stim_data[$];
  logic            stim_end[$];
  longint          stream_total;
  int              last_body_len;
  end_mode_t       end_mode;
  int              sender_idle_pct = 34;
  int              receiver_idle_pct = 88;

  id3v2_frame_parser_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_stream_end        (in_stream_end),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_version_major    (out_version_major),
    .out_version_revision (out_version_revision),
    .out_tag_flags        (out_tag_flags),
    .out_tag_len          (out_tag_len),
    .out_frm_id           (out_frm_id),
    .out_frm_size         (out_frm_size),
    .out_frame_flags      (out_frame_flags),
    .out_zero_byte_present(out_zero_byte_present),
    .out_body_byte        (out_body_byte),
    .out_last             (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic void push_byte(logic [7:0] b);
    stim_data.push_back(b);
    stim_end.push_back(1'b0);
  endfunction

  function automatic void push_eos();
    stim_data.push_back(8'($urandom_range(0, 255)));
    stim_end.push_back(1'b1);
  endfunction

  function automatic logic [31:0] random_id();
    logic [31:0] id;
    if ($urandom_range(0, 3) == 0) begin
      id = $urandom;
    end else begin
      for (int i = 0; i < 4; i++) id[8 * i +: 8] = 8'($urandom_range(8'h41, 8'h5A));
    end
    return id;
  endfunction

  function automatic void push_frame_header(logic [31:0] id, logic [31:0] size,
                                            logic [15:0] flags);
    for (int i = 3; i >= 0; i--) push_byte(id[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) push_byte(size[8 * i +: 8]);
    push_byte(flags[15:8]);
    push_byte(flags[7:0]);
  endfunction

  // first_byte < 0: first body byte random
  function automatic void add_frame(logic [31:0] id, int size, logic [15:0] flags,
                                    int first_byte);
    push_frame_header(id, size, flags);
    for (int k = 0; k < size; k++) begin
      if (k == 0 && first_byte >= 0) push_byte(8'(first_byte));
      else push_byte(8'($urandom_range(0, 255)));
    end
    stream_total += size + 10;
    last_body_len = size;
  endfunction

  function automatic void build_stream();
    logic [27:0] tsize;
    int          size;
    int          cut;
    stream_total = 0;
    for (int i = 0; i < 3; i++) push_byte(TAG_MARKER[23 - 8 * i -: 8]);
    repeat (3) push_byte(8'($urandom_range(0, 255)));
    repeat (4) push_byte(8'h00);
    // size-one frame whose only byte is zero, then all-zero id with 0xff lead
    add_frame(32'hFFFF_FFFF, 1, 16'hFFFF, 0);
    add_frame(32'h0000_0000, 2, 16'h0000, 255);
    while (stim_data.size() < STREAM_TARGET) begin
      size = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      add_frame(random_id(), size, 16'($urandom_range(0, 16'hFFFF)),
                ($urandom_range(0, 3) == 0) ? 0 : -1);
    end
    end_mode = end_mode_t'($urandom_range(0, 3));
    if (end_mode == END_TAG_SIZE) begin
      tsize = 28'(stream_total - $urandom_range(0, last_body_len + 9));
    end else if ($urandom_range(0, 1) == 1) begin
      tsize = 28'hFFF_FFFF;
    end else begin
      tsize = 28'($urandom_range(stream_total + 64, 28'hFFF_FFFF));
    end
    for (int i = 0; i < 4; i++)
      stim_data[6 + i] = {$urandom_range(0, 1) == 1, tsize[27 - 7 * i -: 7]};
    case (end_mode)
      END_TAG_SIZE: begin
        if ($urandom_range(0, 1) == 1) push_eos();
        else push_byte(8'($urandom_range(0, 255)));
      end
      END_ZERO_FRAME: push_frame_header(random_id(), 32'd0, 16'($urandom_range(0, 16'hFFFF)));
      END_IN_BODY: begin
        push_frame_header(random_id(), $urandom | 32'h8000_0000,
                          16'($urandom_range(0, 16'hFFFF)));
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        push_eos();
      end
      default: begin
        cut = $urandom_range(0, 9);
        push_frame_header(random_id(), $urandom_range(1, 255),
                          16'($urandom_range(0, 16'hFFFF)));
        repeat (10 - cut) begin
          void'(stim_data.pop_back());
          void'(stim_end.pop_back());
        end
        push_eos();
      end
    endcase
    // trailing bytes after the parse has closed
    repeat ($urandom_range(3, 8)) begin
      if ($urandom_range(0, 1) == 1) push_eos();
      else push_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic drive_stream();
    int idx;
    idx = 0;
    while (idx < stim_data.size()) begin
      if (idx < stim_data.size() / 3) begin
        sender_idle_pct = 34;
        receiver_idle_pct = 88;
      end else if (idx < 2 * stim_data.size() / 3) begin
        sender_idle_pct = 88;
        receiver_idle_pct = 34;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_valid <= 1'b1;
        in_data_byte <= stim_data[idx];
        in_stream_end <= stim_end[idx];
        do @(posedge clk); while (in_stall);
        sb.note_input(stim_data[idx], stim_end[idx]);
        idx++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    result_t got;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '0;
        got.kind = kind_t'(out_kind);
        got.version_major = out_version_major;
        got.version_revision = out_version_revision;
        got.tag_flags = out_tag_flags;
        got.tag_len = out_tag_len;
        got.frm_id = out_frm_id;
        got.frm_size = out_frm_size;
        got.frame_flags = out_frame_flags;
        got.zero_byte_present = out_zero_byte_present;
        got.body_byte = out_body_byte;
        got.last = out_last;
        sb.check_result(got);
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("id3v2_frame_parser_core test failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_stream_end <= 1'b0;
    sb = new();
    build_stream();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    drive_stream();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Streamed %0d bytes through one tag, closing as %s; %0d records compared.",
             stim_data.size(), end_mode.name(), sb.checked);
    $display("Mismatches: %0d, records still outstanding: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("id3v2_frame_parser_core test passed");
    end else begin
      $display("id3v2_frame_parser_core test failed");
    end
    $finish;
  end

endmodule
